// ===== src/fasta_fastq_record_parser_defines.svh =====
// assertion macros shared by the record parser modules
// expects clk and rst_n in the scope of each use
`ifndef FASTA_FASTQ_RECORD_PARSER_DEFINES_SVH
`define FASTA_FASTQ_RECORD_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
`define FFP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FFP_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define FFP_ASSERT(label, prop, msg)
`define FFP_ASSERT_NEVER(label, expr, msg)
`endif
`endif

// ===== src/ffp_pkg.sv =====
// types, codes and constants of the fasta/fastq record parser
// no dependencies
package ffp_pkg;

    localparam int MAX_RECORD_LENGTH = 1048576;
    localparam int CNT_W             = $clog2(MAX_RECORD_LENGTH + 1);
    localparam int FIFO_DEPTH        = 4;
    localparam int PTR_W             = $clog2(FIFO_DEPTH);
    localparam int FCNT_W            = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CH_FASTA = 8'h3E;  // '>'
    localparam logic [7:0] CH_FASTQ = 8'h40;  // '@'
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    typedef enum logic [2:0] {
        K_HEADER = 3'd0,
        K_BASE   = 3'd1,
        K_END    = 3'd2,
        K_TRUNC  = 3'd3,
        K_ERROR  = 3'd4
    } kind_t;

    typedef enum logic [7:0] {
        PH_AWAIT     = 8'b0000_0001,
        PH_HEADER    = 8'b0000_0010,
        PH_AFTER_HDR = 8'b0000_0100,
        PH_DUP_SKIP  = 8'b0000_1000,
        PH_FASTA_SEQ = 8'b0001_0000,
        PH_FASTQ_SEQ = 8'b0010_0000,
        PH_PLUS      = 8'b0100_0000,
        PH_QUAL      = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        kind_t             kind;
        logic [7:0]        out_byte;
        logic [CNT_W-1:0]  record_length;
        logic              length_saturated;
        logic              record_format;
        logic              last;
    } res_t;

    // up to two results per request
    typedef struct packed {
        logic [1:0] n;
        res_t       r0;
        res_t       r1;
    } push_t;

    function automatic res_t make_res(kind_t k, logic [7:0] b, logic [CNT_W-1:0] len,
                                      logic sat, logic fmt);
        res_t r;
        r.kind             = k;
        r.out_byte         = b;
        r.record_length    = len;
        r.length_saturated = sat;
        r.record_format    = fmt;
        r.last             = 1'b0;
        return r;
    endfunction

endpackage

// ===== src/fasta_fastq_record_parser.sv =====
// fasta/fastq record parser top level: one input byte per cycle while the result queue has room, results queued
// a result is written into the result queue when its input byte is taken, and results leave in order
// input is held off unless the four-entry result queue has two entries free
// a '>' that closes a fasta record gives two results, both queued together
// reset: asynchronous active low, parser awaits a record, keep_case cleared, queue empty
// depends on ffp_pkg, ffp_parse and ffp_out_fifo
module fasta_fastq_record_parser
    import ffp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte
    input  logic [0:0]  s_tuser,   // end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out_byte, record_length, length_saturated, record_format, pad
    output logic [2:0]  m_tuser,   // kind
    output logic        m_tlast,   // last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data   // keep_case
);

    logic  keep_case_reg;
    logic  room2;
    logic  in_fire;
    push_t push;
    res_t  res;

    assign cfg_ready = 1'b1;
    assign s_tready  = room2;
    assign in_fire   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            keep_case_reg <= 1'b0;
        else if (cfg_valid && cfg_ready)
            keep_case_reg <= cfg_data;
    end

    ffp_parse u_parse (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_fire      (in_fire),
        .in_byte      (s_tdata),
        .end_of_input (s_tuser[0]),
        .keep_case    (keep_case_reg),
        .push         (push)
    );

    ffp_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room2     (room2),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {1'b0, res.record_format, res.length_saturated, res.record_length,
                      res.out_byte};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule

// ===== src/ffp_parse.sv =====
// record parser state machine: one input byte per cycle while in_fire is high, up to two results
// depends on ffp_pkg and fasta_fastq_record_parser_defines.svh
`include "fasta_fastq_record_parser_defines.svh"
module ffp_parse
    import ffp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_fire,
    input  logic [7:0] in_byte,
    input  logic       end_of_input,
    input  logic       keep_case,
    output push_t      push
);

    phase_t           phase_reg, phase_next;
    logic             fmt_reg, fmt_next;
    logic             line_start_reg, line_start_next;
    logic             cr_drop_reg, cr_drop_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             sat_reg, sat_next;
    logic             failed_reg, failed_next;

    logic [7:0] marker;
    logic       seq_cr;
    logic [7:0] seq_b;
    logic       cnt_full;
    logic [1:0] n;
    res_t       r0, r1;
    res_t       base_res;

    assign marker   = fmt_reg ? CH_FASTQ : CH_FASTA;
    assign seq_cr   = cr_drop_reg | (in_byte == CH_CR);
    assign seq_b    = (!keep_case && in_byte >= CH_LO_A && in_byte <= CH_LO_Z)
                      ? in_byte - CASE_OFS : in_byte;
    assign cnt_full = cnt_reg >= CNT_W'(MAX_RECORD_LENGTH);
    assign base_res = make_res(K_BASE, seq_b, '0, 1'b0, fmt_reg);

    always_comb
    begin
        phase_next      = phase_reg;
        fmt_next        = fmt_reg;
        line_start_next = line_start_reg;
        cr_drop_next    = cr_drop_reg;
        cnt_next        = cnt_reg;
        sat_next        = sat_reg;
        failed_next     = failed_reg;
        n               = 2'd0;
        r0              = make_res(K_ERROR, '0, '0, 1'b0, 1'b0);
        r1              = make_res(K_ERROR, '0, '0, 1'b0, 1'b0);

        if (in_fire && !failed_reg)
        begin
            if (end_of_input)
            begin
                case (phase_reg)
                    PH_AWAIT: ;
                    PH_HEADER, PH_AFTER_HDR, PH_DUP_SKIP, PH_FASTQ_SEQ:
                    begin
                        n  = 2'd1;
                        r0 = make_res(K_TRUNC, '0, cnt_reg, sat_reg, fmt_reg);
                    end
                    PH_PLUS:
                    begin
                        n  = 2'd1;
                        r0 = make_res(line_start_reg ? K_TRUNC : K_END, '0, cnt_reg,
                                      sat_reg, fmt_reg);
                    end
                    default:
                    begin
                        n  = 2'd1;
                        r0 = make_res(K_END, '0, cnt_reg, sat_reg, fmt_reg);
                    end
                endcase
                phase_next      = PH_AWAIT;
                line_start_next = 1'b1;
                cr_drop_next    = 1'b0;
                cnt_next        = '0;
                sat_next        = 1'b0;
                fmt_next        = 1'b0;
            end
            else
            begin
                case (phase_reg)
                    PH_AWAIT:
                    begin
                        if (in_byte == CH_FASTA || in_byte == CH_FASTQ)
                        begin
                            fmt_next        = (in_byte == CH_FASTQ);
                            cnt_next        = '0;
                            sat_next        = 1'b0;
                            cr_drop_next    = 1'b0;
                            line_start_next = 1'b0;
                            phase_next      = PH_HEADER;
                            n               = 2'd1;
                            r0 = make_res(K_HEADER, in_byte, '0, 1'b0, in_byte == CH_FASTQ);
                        end
                        else
                        begin
                            failed_next = 1'b1;
                            n           = 2'd1;
                        end
                    end
                    PH_HEADER:
                    begin
                        if (in_byte == CH_LF)
                        begin
                            phase_next      = PH_AFTER_HDR;
                            line_start_next = 1'b1;
                            cr_drop_next    = 1'b0;
                        end
                        else
                        begin
                            cr_drop_next = seq_cr;
                            if (!seq_cr)
                            begin
                                n  = 2'd1;
                                r0 = make_res(K_HEADER, in_byte, '0, 1'b0, fmt_reg);
                            end
                        end
                    end
                    PH_AFTER_HDR, PH_FASTA_SEQ, PH_FASTQ_SEQ:
                    begin
                        if (phase_reg == PH_AFTER_HDR && in_byte == marker)
                        begin
                            phase_next      = PH_DUP_SKIP;
                            line_start_next = 1'b0;
                        end
                        else if (phase_reg == PH_FASTA_SEQ && line_start_reg
                                 && in_byte == CH_FASTA)
                        begin
                            // closes this record and opens the next
                            n  = 2'd2;
                            r0 = make_res(K_END, '0, cnt_reg, sat_reg, fmt_reg);
                            r1 = make_res(K_HEADER, in_byte, '0, 1'b0, 1'b0);
                            fmt_next        = 1'b0;
                            cnt_next        = '0;
                            sat_next        = 1'b0;
                            cr_drop_next    = 1'b0;
                            line_start_next = 1'b0;
                            phase_next      = PH_HEADER;
                        end
                        else if (in_byte == CH_LF)
                        begin
                            line_start_next = 1'b1;
                            cr_drop_next    = 1'b0;
                            if (phase_reg != PH_FASTA_SEQ)
                                phase_next = fmt_reg ? PH_PLUS : PH_FASTA_SEQ;
                        end
                        else
                        begin
                            if (phase_reg == PH_AFTER_HDR)
                                phase_next = fmt_reg ? PH_FASTQ_SEQ : PH_FASTA_SEQ;
                            line_start_next = 1'b0;
                            cr_drop_next    = seq_cr;
                            if (!seq_cr)
                            begin
                                n  = 2'd1;
                                r0 = base_res;
                                if (cnt_full)
                                begin
                                    cnt_next = CNT_W'(MAX_RECORD_LENGTH);
                                    sat_next = 1'b1;
                                end
                                else
                                    cnt_next = cnt_reg + 1'b1;
                            end
                        end
                    end
                    PH_DUP_SKIP:
                    begin
                        if (in_byte == CH_LF)
                        begin
                            phase_next      = PH_AFTER_HDR;
                            line_start_next = 1'b1;
                        end
                    end
                    PH_PLUS:
                    begin
                        if (in_byte == CH_LF)
                        begin
                            phase_next      = PH_QUAL;
                            line_start_next = 1'b1;
                        end
                        else
                            line_start_next = 1'b0;
                    end
                    default:
                    begin
                        if (in_byte == CH_LF)
                        begin
                            n               = 2'd1;
                            r0 = make_res(K_END, '0, cnt_reg, sat_reg, fmt_reg);
                            phase_next      = PH_AWAIT;
                            line_start_next = 1'b1;
                            cr_drop_next    = 1'b0;
                            cnt_next        = '0;
                            sat_next        = 1'b0;
                            fmt_next        = 1'b0;
                        end
                        else
                            line_start_next = 1'b0;
                    end
                endcase
            end
        end

        // mark the final result of this request
        if (n == 2'd1)
            r0.last = 1'b1;
        if (n == 2'd2)
            r1.last = 1'b1;
    end

    assign push.n  = n;
    assign push.r0 = r0;
    assign push.r1 = r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_AWAIT;
            fmt_reg        <= 1'b0;
            line_start_reg <= 1'b1;
            cr_drop_reg    <= 1'b0;
            cnt_reg        <= '0;
            sat_reg        <= 1'b0;
            failed_reg     <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            fmt_reg        <= fmt_next;
            line_start_reg <= line_start_next;
            cr_drop_reg    <= cr_drop_next;
            cnt_reg        <= cnt_next;
            sat_reg        <= sat_next;
            failed_reg     <= failed_next;
        end
    end

    `FFP_ASSERT(a_failed_sticky, failed_reg |=> failed_reg, "format error cleared without reset")
    `FFP_ASSERT(a_eoi_closes, (in_fire && end_of_input && !failed_reg) |=> (phase_reg == PH_AWAIT && cnt_reg == '0), "end of input left a record open")
    `FFP_ASSERT_NEVER(a_cnt_range, cnt_reg > CNT_W'(MAX_RECORD_LENGTH), "base count beyond saturation limit")
    `FFP_ASSERT_NEVER(a_no_result_failed, failed_reg && push.n != 2'd0, "result produced after format error")

endmodule

// ===== src/ffp_out_fifo.sv =====
// result queue: up to two results written per cycle, one read per cycle while out_ready is high
// depends on ffp_pkg and fasta_fastq_record_parser_defines.svh
`include "fasta_fastq_record_parser_defines.svh"
module ffp_out_fifo
    import ffp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  push_t push,
    output logic  room2,
    output logic  out_valid,
    input  logic  out_ready,
    output res_t  out_res
);

    res_t              mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_reg, wr_next;
    logic [PTR_W-1:0]  rd_reg, rd_next;
    logic [FCNT_W-1:0] count_reg, count_next;
    logic              pop;

    assign out_valid = count_reg != '0;
    assign out_res   = mem[rd_reg];
    assign pop       = out_valid && out_ready;
    assign room2     = count_reg <= FCNT_W'(FIFO_DEPTH - 2);

    assign wr_next    = wr_reg + PTR_W'(push.n);
    assign rd_next    = rd_reg + PTR_W'(pop);
    assign count_next = count_reg + FCNT_W'(push.n) - FCNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
            mem[wr_reg] <= push.r0;
        if (push.n == 2'd2)
            mem[wr_reg + 1'b1] <= push.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    `FFP_ASSERT_NEVER(a_overflow, FCNT_W'(push.n) > FCNT_W'(FIFO_DEPTH) - count_reg, "result queue overflow")
    `FFP_ASSERT_NEVER(a_count_range, count_reg > FCNT_W'(FIFO_DEPTH), "result queue count out of range")
    `FFP_ASSERT(a_hold_out, (out_valid && !out_ready) |=> out_valid, "waiting result withdrawn")

endmodule

// ===== sim/fasta_fastq_record_parser_test.sv =====
// self-checking testbench for fasta_fastq_record_parser: byte stream in, parsed results out
// predicts every result in a scoreboard class and checks them in order on the result stream
// depends on ffp_pkg and the parser rtl only
module fasta_fastq_record_parser_test
    import ffp_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          QUIET_LIMIT = 1000;
    localparam int          RUN_BASES   = 40;
    localparam logic [7:0]  PLUS_MARK   = 8'h2B;  // '+'
    localparam logic [7:0]  BASE_N      = 8'h4E;  // 'N'
    localparam logic [7:0]  ERR_BYTE    = 8'h2A;  // '*'

    // parser predictor plus the queue of results still due
    class parsed_stream;
        res_t             due[$];
        res_t             staged[2];
        int               n_staged;
        bit               keep_case;
        phase_t           ph;
        logic             fmt;
        logic             line_start;
        logic             cr_drop;
        logic             sat;
        logic             failed;
        logic [CNT_W-1:0] count;
        int               errors;

        function new();
            clear_record();
            failed    = 1'b0;
            keep_case = 1'b0;
            errors    = 0;
        endfunction

        function void clear_record();
            ph         = PH_AWAIT;
            line_start = 1'b1;
            cr_drop    = 1'b0;
            count      = '0;
            sat        = 1'b0;
            fmt        = 1'b0;
        endfunction

        function void stage(kind_t k, logic [7:0] b, logic [CNT_W-1:0] len, logic s, logic f);
            res_t r;
            r.kind             = k;
            r.out_byte         = b;
            r.record_length    = len;
            r.length_saturated = s;
            r.record_format    = f;
            r.last             = 1'b0;
            staged[n_staged]   = r;
            n_staged++;
        endfunction

        function void close_record(kind_t k);
            stage(k, 8'h00, count, sat, fmt);
        endfunction

        function void open_record(logic f);
            fmt        = f;
            count      = '0;
            sat        = 1'b0;
            cr_drop    = 1'b0;
            line_start = 1'b0;
            ph         = PH_HEADER;
        endfunction

        function void sequence_byte(logic [7:0] b);
            logic [7:0] c;
            c          = b;
            line_start = 1'b0;
            if (c == CH_CR)
                cr_drop = 1'b1;
            if (cr_drop)
                return;
            if (!keep_case && c >= CH_LO_A && c <= CH_LO_Z)
                c = c - CASE_OFS;
            // count sticks at the maximum once the record overflows
            if (count >= MAX_RECORD_LENGTH)
            begin
                count = CNT_W'(MAX_RECORD_LENGTH);
                sat   = 1'b1;
            end
            else
                count = count + 1'b1;
            stage(K_BASE, c, '0, 1'b0, fmt);
        endfunction

        function void take_byte(logic [7:0] b, logic eoi);
            logic [7:0] marker;
            n_staged = 0;
            if (failed)
                return;
            if (eoi)
            begin
                case (ph)
                    PH_AWAIT: ;
                    PH_HEADER, PH_AFTER_HDR, PH_DUP_SKIP, PH_FASTQ_SEQ: close_record(K_TRUNC);
                    PH_PLUS: close_record(line_start ? K_TRUNC : K_END);
                    default: close_record(K_END);
                endcase
                clear_record();
            end
            else
            begin
                marker = fmt ? CH_FASTQ : CH_FASTA;
                case (ph)
                    PH_AWAIT:
                        if (b == CH_FASTA || b == CH_FASTQ)
                        begin
                            open_record(b == CH_FASTQ);
                            stage(K_HEADER, b, '0, 1'b0, fmt);
                        end
                        else
                        begin
                            failed = 1'b1;
                            stage(K_ERROR, 8'h00, '0, 1'b0, 1'b0);
                        end
                    PH_HEADER:
                        if (b == CH_LF)
                        begin
                            ph         = PH_AFTER_HDR;
                            line_start = 1'b1;
                            cr_drop    = 1'b0;
                        end
                        else
                        begin
                            if (b == CH_CR)
                                cr_drop = 1'b1;
                            if (!cr_drop)
                                stage(K_HEADER, b, '0, 1'b0, fmt);
                        end
                    PH_AFTER_HDR:
                        if (b == marker)
                        begin
                            ph         = PH_DUP_SKIP;
                            line_start = 1'b0;
                        end
                        else if (b == CH_LF)
                        begin
                            // an empty line still counts as the sequence line
                            ph         = fmt ? PH_PLUS : PH_FASTA_SEQ;
                            line_start = 1'b1;
                            cr_drop    = 1'b0;
                        end
                        else
                        begin
                            ph = fmt ? PH_FASTQ_SEQ : PH_FASTA_SEQ;
                            sequence_byte(b);
                        end
                    PH_DUP_SKIP:
                        if (b == CH_LF)
                        begin
                            ph         = PH_AFTER_HDR;
                            line_start = 1'b1;
                        end
                    PH_FASTA_SEQ:
                        if (line_start && b == CH_FASTA)
                        begin
                            close_record(K_END);
                            open_record(1'b0);
                            stage(K_HEADER, b, '0, 1'b0, 1'b0);
                        end
                        else if (b == CH_LF)
                        begin
                            line_start = 1'b1;
                            cr_drop    = 1'b0;
                        end
                        else
                            sequence_byte(b);
                    PH_FASTQ_SEQ:
                        if (b == CH_LF)
                        begin
                            ph         = PH_PLUS;
                            line_start = 1'b1;
                            cr_drop    = 1'b0;
                        end
                        else
                            sequence_byte(b);
                    PH_PLUS:
                        if (b == CH_LF)
                        begin
                            ph         = PH_QUAL;
                            line_start = 1'b1;
                        end
                        else
                            line_start = 1'b0;
                    default:
                        if (b == CH_LF)
                        begin
                            close_record(K_END);
                            clear_record();
                        end
                        else
                            line_start = 1'b0;
                endcase
            end
            if (n_staged > 0)
                staged[n_staged-1].last = 1'b1;
            for (int i = 0; i < n_staged; i++)
                due.push_back(staged[i]);
        endfunction

        function void compare_field(string field, logic [31:0] want_v, logic [31:0] got_v);
            if (got_v !== want_v)
            begin
                errors++;
                $display("%0t  %s mismatch: expected %0h, got %0h",
                         $time, field, want_v, got_v);
            end
        endfunction

        function void match_result(res_t got);
            res_t want;
            if (due.size() == 0)
            begin
                errors++;
                $display("%0t  result with nothing due: expected none, got kind %0d byte %02h",
                         $time, got.kind, got.out_byte);
                return;
            end
            want = due.pop_front();
            compare_field("kind", want.kind, got.kind);
            compare_field("out_byte", want.out_byte, got.out_byte);
            compare_field("record_length", want.record_length, got.record_length);
            compare_field("length_saturated", want.length_saturated, got.length_saturated);
            compare_field("record_format", want.record_format, got.record_format);
            compare_field("last", want.last, got.last);
        endfunction

        function int outstanding();
            return due.size();
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;  // in_byte
    logic [0:0]  s_tuser   = 1'b0;   // end_of_input
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;            // out_byte, record_length, length_saturated, record_format
    logic [2:0]  m_tuser;            // kind
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data  = 1'b0;   // keep_case

    parsed_stream stream = new;
    logic [8:0]   rec_q[$];          // {end_of_input, byte}
    bit           src_idle  = 1'b1;
    bit           sink_idle = 1'b1;
    int           sink_wait = 0;
    int           quiet     = 0;
    int           sent      = 0;

    fasta_fastq_record_parser DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // result side: random stalls, or none while sink_idle is clear
    always @(posedge clk)
    begin
        int nxt;
        if (!m_tready)
        begin
            if (sink_wait == 0)
                m_tready <= 1'b1;
            else
                sink_wait <= sink_wait - 1;
        end
        else if (m_tvalid)
        begin
            nxt = sink_idle ? $urandom_range(0, 17) : 0;
            if (nxt != 0)
            begin
                m_tready  <= 1'b0;
                sink_wait <= nxt - 1;
            end
        end
    end

    // note each accepted byte before checking, so results of the same edge line up
    always @(posedge clk)
    begin
        res_t got;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                stream.take_byte(s_tdata, s_tuser[0]);
            if (m_tvalid && m_tready)
            begin
                got.kind             = kind_t'(m_tuser);
                got.out_byte         = m_tdata[7:0];
                got.record_length    = m_tdata[8 +: CNT_W];
                got.length_saturated = m_tdata[8 + CNT_W];
                got.record_format    = m_tdata[9 + CNT_W];
                got.last             = m_tlast;
                stream.match_result(got);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet == QUIET_LIMIT)
        begin
            $display("%0t  no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [7:0] any_but_lf();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        return (b == CH_LF) ? BASE_N : b;
    endfunction

    function automatic logic [7:0] base_char();
        string bases;
        bases = "ACGTNacgtn";
        if ($urandom_range(0, 3) == 0)
            return any_but_lf();
        return bases[$urandom_range(0, 9)];
    endfunction

    task automatic send_item(input logic [7:0] b, input logic eoi);
        int gap;
        gap = src_idle ? $urandom_range(0, 17) : 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= b;
        s_tuser  <= eoi;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        sent++;
    endtask

    task automatic send_queue();
        foreach (rec_q[i])
            send_item(rec_q[i][7:0], rec_q[i][8]);
        rec_q.delete();
    endtask

    task automatic put_byte(input logic [7:0] b);
        rec_q.push_back({1'b0, b});
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i]);
    endtask

    task automatic put_eoi();
        rec_q.push_back({1'b1, 8'($urandom_range(0, 255))});
    endtask

    // line end, now and then with a CR and some trailing junk first
    task automatic end_line();
        if ($urandom_range(0, 5) == 0)
        begin
            put_byte(CH_CR);
            repeat ($urandom_range(0, 3)) put_byte(any_but_lf());
        end
        put_byte(CH_LF);
    endtask

    // stop sending, let every due result come out, then the tail of the pipeline
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (stream.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_keep_case(input bit k);
        wait_idle();
        cfg_data  <= k;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid        <= 1'b0;
        stream.keep_case = k;
    endtask

    // one mostly well-formed record with random content, sometimes cut short
    task automatic add_record();
        logic [7:0] marker;
        logic [7:0] b;
        bit         fq;
        int         len;
        int         cut;
        fq     = 1'($urandom_range(0, 1));
        marker = fq ? CH_FASTQ : CH_FASTA;
        put_byte(marker);
        repeat ($urandom_range(0, 8)) put_byte(any_but_lf());
        end_line();
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2))
            begin
                put_byte(marker);
                repeat ($urandom_range(0, 4)) put_byte(any_but_lf());
                end_line();
            end
        if (fq)
        begin
            len = $urandom_range(0, 12);
            for (int i = 0; i < len; i++)
            begin
                b = base_char();
                put_byte((i == 0 && b == CH_FASTQ) ? BASE_N : b);
            end
            end_line();
            put_byte(PLUS_MARK);
            repeat ($urandom_range(0, 3)) put_byte(any_but_lf());
            end_line();
            repeat (len) put_byte(8'($urandom_range(33, 126)));
            put_byte(CH_LF);
        end
        else
            repeat ($urandom_range(1, 3))
            begin
                len = $urandom_range(0, 12);
                for (int i = 0; i < len; i++)
                begin
                    // fasta lines may carry any byte, line feeds included
                    b = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255)) : base_char();
                    put_byte((i == 0 && b == CH_FASTA) ? BASE_N : b);
                end
                end_line();
            end
        case ($urandom_range(0, 9))
            0, 1:
            begin
                cut   = $urandom_range(1, rec_q.size() - 1);
                rec_q = rec_q[0:cut-1];
                put_eoi();
            end
            2, 3: put_eoi();
            4:
            begin
                put_eoi();
                put_eoi();
            end
            default: ;
        endcase
        send_queue();
    endtask

    initial
    begin
        int start;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_keep_case(1'b0);

        // header with CR tail, repeated header, extreme bytes, '>' closing, cut in header
        put_text(">a");
        put_byte(CH_CR);
        put_text("z");
        put_byte(CH_LF);
        put_text(">dup");
        put_byte(CH_LF);
        put_text("ac");
        put_byte(8'hFF);
        put_byte(8'h00);
        put_byte(CH_LF);
        put_byte(CH_FASTA);
        put_eoi();
        // fastq with an empty sequence line, then end of input while awaiting
        put_byte(CH_FASTQ);
        put_byte(CH_LF);
        put_byte(CH_LF);
        put_byte(PLUS_MARK);
        put_byte(CH_LF);
        put_byte(CH_LF);
        put_eoi();
        send_queue();

        for (int p = 0; p < 6; p++)
        begin
            set_keep_case((p < 2) ? (p == 0) : 1'($urandom_range(0, 1)));
            start = sent;
            while (sent - start < 115)
            begin
                if ($urandom_range(0, 5) == 0)
                    src_idle = !src_idle;
                if ($urandom_range(0, 5) == 0)
                    sink_idle <= !sink_idle;
                add_record();
            end
        end

        // one record at full rate on both sides, closed by a '>' line
        set_keep_case(1'b1);
        src_idle = 1'b0;
        sink_idle <= 1'b0;
        send_item(CH_FASTA, 1'b0);
        send_item(CH_LF, 1'b0);
        for (int i = 0; i < RUN_BASES; i++)
            send_item(base_char() | 8'h40, 1'b0);
        send_item(CH_LF, 1'b0);
        send_item(CH_FASTA, 1'b0);
        send_item(8'h00, 1'b1);

        // format error, after which everything is ignored
        wait_idle();
        src_idle = 1'b1;
        sink_idle <= 1'b1;
        case ($urandom_range(0, 2))
            0: send_item(CH_LF, 1'b0);
            1: send_item(CH_CR, 1'b0);
            default: send_item(ERR_BYTE, 1'b0);
        endcase
        repeat (6) send_item(8'($urandom_range(0, 255)), 1'b0);
        send_item(CH_FASTA, 1'b0);
        send_item(8'h00, 1'b1);

        wait_idle();
        repeat (10) @(posedge clk);
        if (stream.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/ffp_pkg.sv
src/ffp_parse.sv
src/ffp_out_fifo.sv
src/fasta_fastq_record_parser.sv
sim/fasta_fastq_record_parser_test.sv
